// ===== hw/rtl/bm3_pkg.sv =====
// bm3_pkg: shared constants, codes and types for the 3x3 binary morphology block
// no dependencies; imported by every module of the block but bm3_ram
package bm3_pkg;

    // geometry
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MASK_SIZE     = 3;
    localparam int HALF          = MASK_SIZE / 2;
    localparam int WIN_BITS      = MASK_SIZE * MASK_SIZE;

    // window shift keeps the two left columns of each row
    localparam logic [WIN_BITS-1:0] WIN_KEEP = 9'h0DB;

    // field widths
    localparam int PIX_W = 8;
    localparam int FW_W  = 11;
    localparam int FH_W  = 16;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 2'd0,
        CFG_MASK   = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        MODE_ERODE  = 1'b0,
        MODE_DILATE = 1'b1
    } t_mode;

    typedef enum logic {
        CMD_PIXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } t_cmd;

    // register reset values
    localparam t_mode               MODE_RST   = MODE_ERODE;
    localparam logic [WIN_BITS-1:0] MASK_RST   = 9'h1FF;
    localparam logic [FW_W-1:0]     WIDTH_RST  = 11'd1024;
    localparam logic [FH_W-1:0]     HEIGHT_RST = 16'd768;

    // result queue
    localparam int OFIFO_DEPTH = 3;
    localparam int OF_CNT_W    = $clog2(OFIFO_DEPTH + 1);
    localparam int OF_PTR_W    = $clog2(OFIFO_DEPTH);

    // control word handed from the sequencer to the window stage
    typedef struct packed {
        logic pix_en;     // a pixel: read-modify-write of the line store
        logic fg;         // foreground bit of the pixel
        logic emit;       // this word gives a result
        logic use_win;    // result comes from the window (not a drained flush)
        logic on_border;  // result position lies on the image border
        logic frame_end;  // result is the last of the frame
    } t_s0_word;

endpackage

// ===== hw/rtl/bm3_ram.sv =====
// bm3_ram: generic single-clock RAM, one write and one registered read port
// depends on nothing
module bm3_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/bm3_seq.sv =====
// bm3_seq: input/output position counters, backlog and per-word decisions
// depends on bm3_pkg
module bm3_seq #(
    parameter int MAX_WIDTH = bm3_pkg::MAX_WIDTH_DEF,
    parameter int COL_W     = $clog2(MAX_WIDTH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  bm3_pkg::t_cmd        i_command,
    input  logic                 i_fg,
    input  logic [bm3_pkg::FW_W-1:0] i_frame_width,
    input  logic [bm3_pkg::FH_W-1:0] i_frame_height,
    output bm3_pkg::t_s0_word    o_word,
    output logic [COL_W-1:0]     o_col
);
    import bm3_pkg::*;

    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int BL_W  = $clog2(MAX_WIDTH + 3);
    localparam int CMP_W = ((WID_W > FW_W) ? WID_W : FW_W) + 2;
    localparam int ROW_X = FH_W + 1;

    logic [COL_W-1:0] r_in_col,  n_in_col;
    logic [FH_W-1:0]  r_in_row,  n_in_row;
    logic [COL_W-1:0] r_out_col, n_out_col;
    logic [FH_W-1:0]  r_out_row, n_out_row;
    logic [BL_W-1:0]  r_backlog, n_backlog;

    logic [CMP_W-1:0] w_eff;
    logic [CMP_W-1:0] fw_ext;
    logic [ROW_X-1:0] h_eff;
    logic [CMP_W-1:0] bl_ext;
    logic             is_pix;
    logic             pix_emit;
    logic             flush_ok;
    logic             emit;
    logic             out_border;
    logic             out_last;
    logic [COL_W-1:0] in_col_adv,  out_col_adv;
    logic [FH_W-1:0]  in_row_adv,  out_row_adv;

    // effective geometry
    always_comb begin
        fw_ext = CMP_W'(i_frame_width);
        if (i_frame_width == '0) begin
            w_eff = CMP_W'(1);
        end else if (fw_ext > CMP_W'(MAX_WIDTH)) begin
            w_eff = CMP_W'(MAX_WIDTH);
        end else begin
            w_eff = fw_ext;
        end
        h_eff = (i_frame_height == '0) ? ROW_X'(1) : ROW_X'(i_frame_height);
    end

    // raster advance of the input position
    always_comb begin
        in_col_adv = r_in_col + COL_W'(1);
        in_row_adv = r_in_row;
        if (CMP_W'(r_in_col) + CMP_W'(1) >= w_eff) begin
            in_col_adv = '0;
            in_row_adv = r_in_row + FH_W'(1);
            if (ROW_X'(r_in_row) + ROW_X'(1) >= h_eff) begin
                in_row_adv = '0;
            end
        end
    end

    // raster advance of the output position
    always_comb begin
        out_col_adv = r_out_col + COL_W'(1);
        out_row_adv = r_out_row;
        if (CMP_W'(r_out_col) + CMP_W'(1) >= w_eff) begin
            out_col_adv = '0;
            out_row_adv = r_out_row + FH_W'(1);
            if (ROW_X'(r_out_row) + ROW_X'(1) >= h_eff) begin
                out_row_adv = '0;
            end
        end
    end

    // border and last-position tests at the output position
    always_comb begin
        out_border = (ROW_X'(r_out_row) < ROW_X'(HALF)) ||
                     (CMP_W'(r_out_col) < CMP_W'(HALF)) ||
                     (ROW_X'(r_out_row) + ROW_X'(HALF) >= h_eff) ||
                     (CMP_W'(r_out_col) + CMP_W'(HALF) >= w_eff);
        out_last   = (ROW_X'(r_out_row) == h_eff - ROW_X'(1)) &&
                     (CMP_W'(r_out_col) == w_eff - CMP_W'(1));
    end

    // per-word decisions
    always_comb begin
        is_pix   = (i_command == CMD_PIXEL);
        bl_ext   = CMP_W'(r_backlog);
        pix_emit = (bl_ext >= w_eff + CMP_W'(1));
        flush_ok = (r_backlog != '0) && (r_in_col == '0) && (r_in_row == '0);
        emit     = is_pix ? pix_emit : flush_ok;

        o_word.pix_en    = is_pix;
        o_word.fg        = i_fg;
        o_word.emit      = emit;
        o_word.use_win   = is_pix;
        o_word.on_border = out_border;
        o_word.frame_end = out_last;
        o_col            = r_in_col;
    end

    // next state of the counters
    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_backlog = r_backlog;
        if (i_fire) begin
            if (is_pix) begin
                n_in_col = in_col_adv;
                n_in_row = in_row_adv;
                if (!pix_emit) begin
                    n_backlog = r_backlog + BL_W'(1);
                end
            end else if (flush_ok) begin
                n_backlog = r_backlog - BL_W'(1);
            end
            if (emit) begin
                n_out_col = out_col_adv;
                n_out_row = out_row_adv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
            r_backlog <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_backlog <= n_backlog;
        end
    end

`ifndef ASSERT_OFF
    // the backlog never runs past one row plus the window lag
    a_backlog_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_backlog) <= CMP_W'(MAX_WIDTH + 2))
        else $error("bm3_seq: backlog overflow");
`endif

endmodule

// ===== hw/rtl/bm3_window.sv =====
// bm3_window: line-store read-modify-write stage, 3x3 window and result logic
// depends on bm3_pkg; drives the write port of the line-store RAM
module bm3_window #(
    parameter int MAX_WIDTH = bm3_pkg::MAX_WIDTH_DEF,
    parameter int COL_W     = $clog2(MAX_WIDTH)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  bm3_pkg::t_s0_word             i_word,
    input  logic [COL_W-1:0]              i_col,
    input  bm3_pkg::t_mode                i_mode,
    input  logic [bm3_pkg::WIN_BITS-1:0]  i_mask_bits,
    input  logic [1:0]                    i_rd_data,
    output logic                          o_wr_en,
    output logic [COL_W-1:0]              o_wr_addr,
    output logic [1:0]                    o_wr_data,
    output logic                          o_res_valid,
    output logic                          o_res_fg,
    output logic                          o_res_end
);
    import bm3_pkg::*;

    logic                r_s1_valid;
    t_s0_word            r_s1_word;
    logic [COL_W-1:0]    r_s1_col;
    logic [WIN_BITS-1:0] r_window, n_window;
    logic                r_fwd_hit, n_fwd_hit;
    logic [1:0]          r_fwd_data;

    logic [1:0]          line;
    logic                bit_a;
    logic                bit_b;
    logic [WIN_BITS-1:0] hit;
    logic                win_on;

    // line bits: forward the word written in the cycle of the read
    always_comb begin
        line  = r_fwd_hit ? r_fwd_data : i_rd_data;
        bit_a = line[0];
        bit_b = line[1];
    end

    // write-back and window shift
    always_comb begin
        o_wr_en   = r_s1_valid && r_s1_word.pix_en;
        o_wr_addr = r_s1_col;
        o_wr_data = {r_s1_word.fg, bit_b};
        n_window  = ((r_window >> 1) & WIN_KEEP) |
                    {r_s1_word.fg, 2'b00, bit_b, 2'b00, bit_a, 2'b00};
        n_fwd_hit = o_wr_en && i_fire && i_word.pix_en && (i_col == r_s1_col);
    end

    // erosion or dilation over the masked window
    always_comb begin
        hit = n_window & i_mask_bits;
        if (i_mode == MODE_DILATE) begin
            win_on = (hit != '0);
        end else begin
            win_on = (hit == i_mask_bits);
        end
        o_res_valid = r_s1_valid && r_s1_word.emit;
        o_res_fg    = r_s1_word.use_win && !r_s1_word.on_border && win_on;
        o_res_end   = r_s1_word.frame_end;
    end

    // stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_window   <= '0;
            r_fwd_hit  <= 1'b0;
        end else begin
            r_s1_valid <= i_fire;
            r_fwd_hit  <= n_fwd_hit;
            if (o_wr_en) begin
                r_window <= n_window;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_s1_word <= i_word;
            r_s1_col  <= i_col;
        end
        r_fwd_data <= o_wr_data;
    end

`ifndef ASSERT_OFF
    // a forwarded word always comes from a write in the previous cycle
    a_fwd_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd_hit |-> ($past(o_wr_en) && r_s1_valid && r_s1_word.pix_en))
        else $error("bm3_window: forward without a matching write");
`endif

endmodule

// ===== hw/rtl/bm3_ofifo.sv =====
// bm3_ofifo: three-word result queue between the window stage and the output port
// depends on bm3_pkg
module bm3_ofifo (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic                          i_fg,
    input  logic                          i_end,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic                          o_fg,
    output logic                          o_end,
    output logic [bm3_pkg::OF_CNT_W-1:0]  o_count
);
    import bm3_pkg::*;

    logic                r_fg  [OFIFO_DEPTH];
    logic                r_end [OFIFO_DEPTH];
    logic [OF_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [OF_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [OF_CNT_W-1:0] r_count,  n_count;
    logic                pop;

    // pointer and count update
    always_comb begin
        pop      = (r_count != '0) && !i_stall;
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == OF_PTR_W'(OFIFO_DEPTH - 1)) ? '0 : r_wr_ptr + OF_PTR_W'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == OF_PTR_W'(OFIFO_DEPTH - 1)) ? '0 : r_rd_ptr + OF_PTR_W'(1);
        end
        n_count = r_count + OF_CNT_W'(i_push) - OF_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_fg[r_wr_ptr]  <= i_fg;
            r_end[r_wr_ptr] <= i_end;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_fg    = r_fg[r_rd_ptr];
    assign o_end   = r_end[r_rd_ptr];
    assign o_count = r_count;

`ifndef ASSERT_OFF
    // the input stall keeps a word from arriving at a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !pop && (r_count == OF_CNT_W'(OFIFO_DEPTH))))
        else $error("bm3_ofifo: push into full queue");

    // last word taken with nothing arriving leaves the queue empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_push && (r_count == OF_CNT_W'(1))) |=> !o_valid)
        else $error("bm3_ofifo: valid stuck after drain");
`endif

endmodule

// ===== hw/rtl/binary_morphology_3x3_top.sv =====
// binary_morphology_3x3_top: streaming 3x3 binary erosion / dilation
// depends on bm3_pkg, bm3_ram, bm3_seq, bm3_window, bm3_ofifo
//
// Usage:
//   Input channel (i_in_valid / o_in_stall) takes one word per cycle unless stalled:
//   i_command selects a raster-order pixel (bit 0 of i_pixel_in is its foreground
//   bit) or a flush, which drains one pending result once a whole frame has been
//   given. Output channel (o_out_valid / i_out_stall) gives o_pixel_out (0 or 255)
//   and o_frame_end on the last position of the frame. Border positions give 0.
//   Results trail the pixels by one row plus one pixel; a pixel word that does
//   not yet complete a window gives no result, nor does an ignored flush.
//   Configuration (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data) writes
//   mode, mask, width and height; o_cfg_ready is always high. Write only when idle.
//   Throughput: one word per cycle, sustained while i_out_stall is low. The line
//   store is a single 2-bit-wide RAM read and written once per pixel; a
//   same-column read in the cycle of a write is served by forwarding.
//   Each result goes through the window stage register and the result queue.
//   Stall: a three-word result queue absorbs the pipeline; o_in_stall rises only
//   while the queue and the window stage hold that many results.
//   Reset: synchronous, active low; counters, window and queue clear, registers
//   return to erosion, full mask, 1024 x 768. The line store needs no clearing.
module binary_morphology_3x3_top #(
    parameter int MAX_WIDTH = bm3_pkg::MAX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_command,
    input  logic [bm3_pkg::PIX_W-1:0]       i_pixel_in,
    // output channel
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [bm3_pkg::PIX_W-1:0]       o_pixel_out,
    output logic                            o_frame_end,
    // configuration
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bm3_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bm3_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import bm3_pkg::*;

    localparam int COL_W = $clog2(MAX_WIDTH);

    t_mode               r_mode;
    logic [WIN_BITS-1:0] r_mask_bits;
    logic [FW_W-1:0]     r_frame_width;
    logic [FH_W-1:0]     r_frame_height;

    logic                fire;
    t_s0_word            s0_word;
    logic [COL_W-1:0]    s0_col;
    logic [1:0]          rd_data;
    logic                wr_en;
    logic [COL_W-1:0]    wr_addr;
    logic [1:0]          wr_data;
    logic                res_valid;
    logic                res_fg;
    logic                res_end;
    logic                q_fg;
    logic [OF_CNT_W-1:0] q_count;
    logic [OF_CNT_W:0]   pending;

    // configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_RST;
            r_mask_bits    <= MASK_RST;
            r_frame_width  <= WIDTH_RST;
            r_frame_height <= HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MODE:   r_mode         <= t_mode'(i_cfg_data[0]);
                CFG_MASK:   r_mask_bits    <= i_cfg_data[WIN_BITS-1:0];
                CFG_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                CFG_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input stall: room for every result in flight plus one more
    always_comb begin
        pending    = (OF_CNT_W + 1)'(q_count) + (OF_CNT_W + 1)'(res_valid);
        o_in_stall = (pending > (OF_CNT_W + 1)'(OFIFO_DEPTH - 1));
        fire       = i_in_valid && !o_in_stall;
    end

    // position counters and per-word decisions
    bm3_seq #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_command      (t_cmd'(i_command)),
        .i_fg           (i_pixel_in[0]),
        .i_frame_width  (r_frame_width),
        .i_frame_height (r_frame_height),
        .o_word         (s0_word),
        .o_col          (s0_col)
    );

    // line store: bit 0 the row two above, bit 1 the row just above
    bm3_ram #(
        .WIDTH (2),
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (fire && s0_word.pix_en),
        .i_raddr (s0_col),
        .o_rdata (rd_data)
    );

    // window and result
    bm3_window #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_W     (COL_W)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_word      (s0_word),
        .i_col       (s0_col),
        .i_mode      (r_mode),
        .i_mask_bits (r_mask_bits),
        .i_rd_data   (rd_data),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_res_valid (res_valid),
        .o_res_fg    (res_fg),
        .o_res_end   (res_end)
    );

    // result queue
    bm3_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_fg    (res_fg),
        .i_end   (res_end),
        .i_stall (i_out_stall),
        .o_valid (o_out_valid),
        .o_fg    (q_fg),
        .o_end   (o_frame_end),
        .o_count (q_count)
    );

    assign o_pixel_out = {PIX_W{q_fg}};

endmodule

// ===== sim/tb_top.sv =====
// tb_top: self-checking bench for the streaming 3x3 binary erosion / dilation block
// depends on bm3_pkg and binary_morphology_3x3_top; a built-in line/window model predicts
// every result word, which is compared field by field as it leaves the block
`timescale 1ns / 1ps

module tb_top;
    import bm3_pkg::*;

    localparam int          LINE_LEN   = 1024;
    localparam int          FILL_W     = 40;
    localparam int          HALF_WIN   = 1;
    localparam int          IDLE_LIMIT = 1000;
    localparam logic [8:0]  KEEP_LEFT  = 9'h0DB;
    localparam logic [7:0]  PIX_ON     = 8'hFF;
    localparam int unsigned RAND_WORDS = 400;

    typedef struct {
        t_cmd       cmd;
        logic [7:0] pix;
    } t_word;

    typedef struct {
        logic [7:0] pix;
        logic       fe;
    } t_result;

    // block inputs, all known from time zero
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  i_command   = 1'b0;
    logic [PIX_W-1:0]      i_pixel_in  = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [PIX_W-1:0]      o_pixel_out;
    logic                  o_frame_end;
    logic                  o_cfg_ready;

    binary_morphology_3x3_top #(
        .MAX_WIDTH (LINE_LEN)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_command   (i_command),
        .i_pixel_in  (i_pixel_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_pixel_out (o_pixel_out),
        .o_frame_end (o_frame_end),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // stimulus words waiting to be sent, and result words still due
    t_word   stream_q[$];
    t_result due_q[$];

    // model of the block: register copies, line store, window and positions
    t_mode       cfg_mode   = MODE_RST;
    logic [8:0]  cfg_mask   = MASK_RST;
    logic [10:0] cfg_width  = WIDTH_RST;
    logic [15:0] cfg_height = HEIGHT_RST;
    bit          upper_line [LINE_LEN];
    bit          middle_line [LINE_LEN];
    logic [8:0]  win_bits   = '0;
    int unsigned in_col     = 0;
    int unsigned in_row     = 0;
    int unsigned out_col    = 0;
    int unsigned out_row    = 0;
    int unsigned in_flight  = 0;

    // bench state
    bit          word_taken   = 1'b0;
    bit          idle_on      = 1'b1;
    bit          quiet        = 1'b0;
    int          gap_left     = 0;
    int          stall_left   = 0;
    int          idle_cycles  = 0;
    int unsigned fg_pct       = 50;
    int unsigned useful_words = 0;
    int unsigned mismatches   = 0;
    int unsigned pixels_taken = 0;
    int unsigned flush_taken  = 0;
    int unsigned results_seen = 0;
    int unsigned cfg_writes   = 0;

    function automatic int unsigned span_w();
        if (cfg_width == 0) return 1;
        if (cfg_width > LINE_LEN) return LINE_LEN;
        return cfg_width;
    endfunction

    function automatic int unsigned span_h();
        return (cfg_height == 0) ? 1 : cfg_height;
    endfunction

    // raster step with wrap at the current frame limits
    function automatic void advance_pos(inout int unsigned col, inout int unsigned row);
        col++;
        if (col >= span_w()) begin
            col = 0;
            row++;
            if (row >= span_h()) row = 0;
        end
    endfunction

    function automatic bit on_border(int unsigned col, int unsigned row);
        return (row < HALF_WIN || col < HALF_WIN ||
                row + HALF_WIN >= span_h() || col + HALF_WIN >= span_w());
    endfunction

    // produce the result word for the current output position
    function automatic void give_result(bit from_win);
        t_result    r;
        logic [8:0] hit;
        r.pix = '0;
        if (from_win && !on_border(out_col, out_row)) begin
            hit = win_bits & cfg_mask;
            if (cfg_mode == MODE_DILATE) r.pix = (hit != 0) ? PIX_ON : '0;
            else r.pix = (hit == cfg_mask) ? PIX_ON : '0;
        end
        r.fe = (out_row == span_h() - 1 && out_col == span_w() - 1);
        advance_pos(out_col, out_row);
        in_flight--;
        due_q.push_back(r);
    endfunction

    // one accepted stimulus word through the line buffers and window
    function automatic void morph_step(t_word w);
        int unsigned col;
        bit          above2, above1, fg;
        if (w.cmd == CMD_FLUSH) begin
            if (in_flight != 0 && in_col == 0 && in_row == 0) give_result(1'b0);
        end else begin
            col    = (in_col >= LINE_LEN) ? LINE_LEN - 1 : in_col;
            above2 = upper_line[col];
            above1 = middle_line[col];
            fg     = w.pix[0];
            win_bits = ((win_bits >> 1) & KEEP_LEFT) | (9'(above2) << 2) |
                       (9'(above1) << 5) | (9'(fg) << 8);
            upper_line[col]  = above1;
            middle_line[col] = fg;
            advance_pos(in_col, in_row);
            in_flight++;
            if (in_flight > span_w() + 1) give_result(1'b1);
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        mismatches++;
        if (mismatches <= 20)
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // input side acceptance and register mirror
    always @(posedge i_clk) begin
        word_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (word_taken) begin
            if (stream_q[0].cmd == CMD_FLUSH) flush_taken++;
            else pixels_taken++;
            morph_step(stream_q.pop_front());
        end
        if (i_rst_n && i_cfg_valid && o_cfg_ready) begin
            cfg_writes++;
            case (i_cfg_index)
                CFG_MODE:   cfg_mode   = t_mode'(i_cfg_data[0]);
                CFG_MASK:   cfg_mask   = i_cfg_data[8:0];
                CFG_WIDTH:  cfg_width  = i_cfg_data[10:0];
                CFG_HEIGHT: cfg_height = i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // driver: present the head word, hold it while stalled, random gaps
    always @(negedge i_clk) begin
        if (!(i_in_valid && !word_taken)) begin
            if (gap_left > 0) begin
                i_in_valid <= 1'b0;
                gap_left   <= gap_left - 1;
            end else if (stream_q.size() != 0 && idle_on && !quiet &&
                         $urandom_range(0, 9) == 0) begin
                i_in_valid <= 1'b0;
                gap_left   <= $urandom_range(1, 7) - 1;
            end else if (stream_q.size() != 0) begin
                i_in_valid <= 1'b1;
                i_command  <= stream_q[0].cmd;
                i_pixel_in <= stream_q[0].pix;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // receiver back-pressure in bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= stall_left - 1;
        end else if (idle_on && !quiet && $urandom_range(0, 7) == 0) begin
            i_out_stall <= 1'b1;
            stall_left  <= $urandom_range(1, 7) - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // monitor: compare each result word with the oldest one due
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (due_q.size() == 0) begin
                report_mismatch("result with nothing due", 16'(o_pixel_out), '0);
            end else begin
                want = due_q.pop_front();
                if (o_pixel_out !== want.pix)
                    report_mismatch("pixel_out", 16'(o_pixel_out), 16'(want.pix));
                if (o_frame_end !== want.fe)
                    report_mismatch("frame_end", 16'(o_frame_end), 16'(want.fe));
            end
        end
    end

    // watchdog on cycles in which no word moves anywhere
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("[%0t] no progress for %0d cycles, %0d results still due",
                     $time, IDLE_LIMIT, due_q.size());
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [7:0] rand_pixel();
        logic [7:0] v;
        v    = 8'($urandom);
        v[0] = ($urandom_range(0, 99) < fg_pct);
        return v;
    endfunction

    task automatic push_word(input t_cmd cmd, input logic [7:0] pix);
        t_word w;
        w.cmd = cmd;
        w.pix = pix;
        stream_q.push_back(w);
    endtask

    task automatic wait_drained();
        do begin
            @(posedge i_clk);
            #1;
        end while (stream_q.size() != 0);
    endtask

    // quiet point for register writes: nothing queued, nothing due, pipeline empty
    task automatic settle();
        do begin
            @(posedge i_clk);
            #1;
        end while (stream_q.size() != 0 || due_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // register write with junk in the data bits above the register
    task automatic set_reg(input t_cfg_idx idx, input int unsigned val);
        logic [15:0] junk;
        junk = 16'($urandom);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        case (idx)
            CFG_MODE:   i_cfg_data <= {junk[15:1], val[0]};
            CFG_MASK:   i_cfg_data <= {junk[15:9], val[8:0]};
            CFG_WIDTH:  i_cfg_data <= {junk[15:11], val[10:0]};
            default:    i_cfg_data <= val[15:0];
        endcase
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // complete the current frame with pixels, then drain the tail with flushes
    task automatic close_frame(input int unsigned extra);
        int unsigned col, row, n;
        wait_drained();
        col = in_col;
        row = in_row;
        n   = 0;
        while (col != 0 || row != 0) begin
            advance_pos(col, row);
            n++;
        end
        repeat (n) push_word(CMD_PIXEL, rand_pixel());
        wait_drained();
        useful_words += n + in_flight;
        repeat (in_flight + extra) push_word(CMD_FLUSH, 8'($urandom));
    endtask

    initial begin
        logic [7:0]  demo_pix [12];
        int unsigned n, rand_target;
        bit          broken;

        demo_pix = '{8'hFF, 8'h01, 8'hFF, 8'h00,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF,
                     8'h81, 8'hFF, 8'hFF, 8'hFE};

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // widest frame used later, two rows, all border: fills both line banks
        set_reg(CFG_WIDTH, FILL_W);
        set_reg(CFG_HEIGHT, 2);
        set_reg(CFG_MODE, MODE_DILATE);
        set_reg(CFG_MASK, 511);
        repeat (2 * FILL_W) push_word(CMD_PIXEL, rand_pixel());
        close_frame(0);

        // 4x3 erosion, full mask; one inner window all foreground, one not,
        // a flush on an unfinished frame and one with nothing pending
        settle();
        set_reg(CFG_WIDTH, 4);
        set_reg(CFG_HEIGHT, 3);
        set_reg(CFG_MODE, MODE_ERODE);
        foreach (demo_pix[i]) begin
            if (i == 5) push_word(CMD_FLUSH, 8'hFF);
            push_word(CMD_PIXEL, demo_pix[i]);
        end
        close_frame(1);

        // empty mask: erosion gives 255 at the inner position
        settle();
        set_reg(CFG_WIDTH, 3);
        set_reg(CFG_MASK, 0);
        repeat (9) push_word(CMD_PIXEL, 8'($urandom) & 8'hFE);
        close_frame(0);

        // width and height of zero count as one
        settle();
        set_reg(CFG_WIDTH, 0);
        set_reg(CFG_HEIGHT, 0);
        set_reg(CFG_MASK, 511);
        repeat (3) push_word(CMD_PIXEL, PIX_ON);
        close_frame(1);

        // tallest frame, then shrunk mid-frame so both positions wrap
        settle();
        set_reg(CFG_WIDTH, 3);
        set_reg(CFG_HEIGHT, 65535);
        set_reg(CFG_MODE, MODE_DILATE);
        set_reg(CFG_MASK, $urandom_range(1, 511));
        repeat (7) push_word(CMD_PIXEL, rand_pixel());
        settle();
        set_reg(CFG_HEIGHT, 2);
        set_reg(CFG_WIDTH, 2);
        close_frame(0);

        // random frames: mostly whole frames, some cut short, some left undrained
        rand_target = useful_words + RAND_WORDS;
        while (useful_words < rand_target) begin
            if (useful_words + 80 > rand_target) quiet = 1'b1;
            idle_on = ($urandom_range(0, 3) != 0);
            fg_pct  = ($urandom_range(0, 2) == 0) ? 15 : ($urandom_range(0, 1) ? 50 : 90);
            if ($urandom_range(0, 9) < 7) begin
                settle();
                if ($urandom_range(0, 1)) set_reg(CFG_MODE, $urandom_range(0, 1));
                if ($urandom_range(0, 1)) begin
                    case ($urandom_range(0, 3))
                        0:       set_reg(CFG_MASK, 0);
                        1:       set_reg(CFG_MASK, 511);
                        default: set_reg(CFG_MASK, $urandom_range(0, 511));
                    endcase
                end
                if ($urandom_range(0, 1)) begin
                    case ($urandom_range(0, 19))
                        0:       set_reg(CFG_WIDTH, 0);
                        1:       set_reg(CFG_WIDTH, 1);
                        2:       set_reg(CFG_WIDTH, $urandom_range(11, FILL_W));
                        default: set_reg(CFG_WIDTH, $urandom_range(2, 10));
                    endcase
                end
                if ($urandom_range(0, 1))
                    set_reg(CFG_HEIGHT, ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 6));
            end
            n      = span_w() * span_h();
            broken = ($urandom_range(0, 9) == 0);
            if (broken) n = $urandom_range(1, n);
            repeat (n) begin
                if ($urandom_range(0, 15) == 0) push_word(CMD_FLUSH, 8'($urandom));
                push_word(CMD_PIXEL, rand_pixel());
            end
            useful_words += n;
            if (!broken && $urandom_range(0, 2) != 0) close_frame($urandom_range(0, 1));
        end
        close_frame(0);

        // wait out the last results and the pipeline behind them
        do @(posedge i_clk); while (due_q.size() != 0);
        repeat (8) @(posedge i_clk);

        $display("stream covered %0d pixel and %0d flush words, %0d results checked,",
                 pixels_taken, flush_taken, results_seen);
        $display("%0d register writes over both modes, masks and frame sizes; %0d mismatches",
                 cfg_writes, mismatches);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== binary_morphology_3x3_top.f =====
hw/rtl/bm3_pkg.sv
hw/rtl/bm3_ram.sv
hw/rtl/bm3_seq.sv
hw/rtl/bm3_window.sv
hw/rtl/bm3_ofifo.sv
hw/rtl/binary_morphology_3x3_top.sv
sim/tb_top.sv
